// ----- rtl/memory_range_map_engine_core_defines.svh -----
// Assertion macros shared by the range map engine files.
`ifndef MEMORY_RANGE_MAP_ENGINE_CORE_DEFINES_SVH
`define MEMORY_RANGE_MAP_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MRM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MRM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map package
// Shared types, constants and command codes of the range map engine.
// ----------------------------------------------------------------------------
package mrm_pkg;
  localparam int MaxRanges = 16;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = $clog2(MaxRanges + 1);
  localparam int DumpLimit = 16;

  typedef enum logic [2:0] {
    FUNC_CLEAR   = 3'd0,
    FUNC_APPEND  = 3'd1,
    FUNC_SORT    = 3'd2,
    FUNC_CARVE   = 3'd3,
    FUNC_RESERVE = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  range_type;
    logic [63:0] range_start;
    logic [63:0] range_size;
  } req_t;

  typedef struct packed {
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [63:0] entry_start;
    logic [63:0] entry_size;
    logic [7:0]  entry_type;
    logic [4:0]  entry_total;
    logic        overflow;
    logic        last;
  } rsp_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // clear overflow for the new request
    OP_CLEAR,     // count to zero
    OP_APPEND,    // append request range
    OP_SORT_CMP,  // compare/exchange entries i and j
    OP_MERGE,     // try merge i with i+1
    OP_SHIFT_UP,  // delete step: entry k gets k+1
    OP_DEL_DONE,  // decrement count
    OP_CARVE,     // classify/adjust entry i
    OP_SHIFT_DN,  // insert step: entry k gets k-1
    OP_SPLIT,     // shrink entry i, write upper piece at i+1
    OP_RESERVE,   // reserve fixup on entry i
    OP_DUMP       // emit entry k
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] k;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            merge_hit;   // entries i and i+1 merge
    logic            carve_del;   // entry i fully covered
    logic            carve_split; // entry i strictly contains range
    logic            full;
  } stat_t;
endpackage

// ----- rtl/mrm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map datapath
// Range table registers and the per-entry arithmetic for each command.
// ----------------------------------------------------------------------------
`include "memory_range_map_engine_core_defines.svh"
module mrm_datapath import mrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  strobe,
  output rsp_t  result
);
  logic [63:0]     base [MaxRanges];
  logic [63:0]     len  [MaxRanges];
  logic [7:0]      kind [MaxRanges];
  logic [CntW-1:0] count;
  logic            ovf;
  req_t            r;

  logic [IdxW-1:0] ip1;
  logic [63:0]     s, e, ns, ne, rs, re;
  assign ip1 = cmd.i + IdxW'(1);
  assign s   = base[cmd.i];
  assign e   = base[cmd.i] + len[cmd.i];
  assign ns  = base[ip1];
  assign ne  = base[ip1] + len[ip1];
  assign rs  = r.range_start;
  assign re  = r.range_start + r.range_size;

  always_comb begin
    stat.count       = count;
    stat.full        = (count >= CntW'(MaxRanges));
    stat.merge_hit   = (kind[cmd.i] == kind[ip1]) && (s <= ns) && (e > ns);
    stat.carve_del   = (rs <= s) && (re >= e);
    stat.carve_split = (rs > s) && (re < e);
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      // The request is captured at the accepting edge itself.
      if (load) r <= req;
      unique case (cmd.op)
        OP_LOAD: ovf <= 1'b0;
        OP_CLEAR: count <= '0;
        OP_APPEND: begin
          if (!stat.full) begin
            base[count[IdxW-1:0]] <= r.range_start;
            len[count[IdxW-1:0]]  <= r.range_size;
            kind[count[IdxW-1:0]] <= r.range_type;
            count <= count + CntW'(1);
          end else begin
            ovf <= 1'b1;
          end
        end
        OP_SORT_CMP: begin
          if (base[cmd.j] < base[cmd.i]) begin
            base[cmd.i] <= base[cmd.j];
            len[cmd.i]  <= len[cmd.j];
            kind[cmd.i] <= kind[cmd.j];
            base[cmd.j] <= base[cmd.i];
            len[cmd.j]  <= len[cmd.i];
            kind[cmd.j] <= kind[cmd.i];
          end
        end
        OP_MERGE: begin
          if (stat.merge_hit) begin
            len[cmd.i] <= ((e < ne) ? ne : e) - s;
          end
        end
        OP_SHIFT_UP: begin
          base[cmd.k] <= base[cmd.k + IdxW'(1)];
          len[cmd.k]  <= len[cmd.k + IdxW'(1)];
          kind[cmd.k] <= kind[cmd.k + IdxW'(1)];
        end
        OP_DEL_DONE: count <= count - CntW'(1);
        OP_CARVE: begin
          if (stat.carve_split) begin
            len[cmd.i] <= rs - s;
            if (stat.full) ovf <= 1'b1;
          end else if (rs <= s && re > s) begin
            base[cmd.i] <= re;
            len[cmd.i]  <= e - re;
          end else if (rs < e && rs > s) begin
            len[cmd.i] <= rs - s;
          end
        end
        OP_SHIFT_DN: begin
          base[cmd.k] <= base[cmd.k - IdxW'(1)];
          len[cmd.k]  <= len[cmd.k - IdxW'(1)];
          kind[cmd.k] <= kind[cmd.k - IdxW'(1)];
        end
        OP_SPLIT: begin
          // Entry i+1 holds a full copy of entry i, so ne is the old end.
          len[cmd.i] <= rs - s;
          base[ip1]  <= re;
          len[ip1]   <= ne - re;
          kind[ip1]  <= kind[cmd.i];
          count      <= count + CntW'(1);
        end
        OP_RESERVE: begin
          if (e == rs) begin
            len[cmd.i] <= re - s;
          end else if (s == rs) begin
            base[cmd.i] <= re;
            len[cmd.i]  <= e - re;
          end
        end
        OP_DUMP: begin
          strobe             <= 1'b1;
          result.entry_index <= cmd.k[3:0];
          result.entry_valid <= (count != '0);
          result.entry_start <= (count != '0) ? base[cmd.k] : '0;
          result.entry_size  <= (count != '0) ? len[cmd.k] : '0;
          result.entry_type  <= (count != '0) ? kind[cmd.k] : '0;
          result.entry_total <= 5'(count);
          result.overflow    <= ovf;
          result.last        <= cmd.last;
        end
        default: ;
      endcase
    end
  end

  `MRM_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CntW'(MaxRanges))
  `MRM_ASSERT_NEXT(a_clear_zero, clk, rst, cmd.op == OP_CLEAR, count == '0)
  `MRM_ASSERT_NEXT(a_dump_strobe, clk, rst, cmd.op == OP_DUMP, strobe)
endmodule

// ----- rtl/mrm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map controller
// Sequences sort, merge, carve, fixup and dump steps over the datapath.
// ----------------------------------------------------------------------------
`include "memory_range_map_engine_core_defines.svh"
module mrm_ctrl import mrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  req_t  req,
  input  stat_t stat,
  output logic  busy,
  output logic  load,
  output cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SORT, S_MERGE, S_MERGE_DEL, S_CARVE, S_CARVE_DEL,
    S_SPLIT_SHIFT, S_SPLIT_WR, S_CARVE_APP, S_RESERVE, S_DUMP
  } state_t;

  state_t          state;
  logic [2:0]      func;
  logic [CntW-1:0] i, j, k;
  logic [CntW-1:0] n;
  logic            stat_merge_i, stat_del_i, stat_split_i;
  logic            probe_ok;

  assign busy = (state != S_IDLE);
  assign load = start && (state == S_IDLE);
  assign n = (stat.count > CntW'(DumpLimit)) ? CntW'(DumpLimit) : stat.count;

  // Status is combinational on cmd.i. It describes entry i only once cmd.i has
  // been set to i and no command is changing the table.
  assign stat_merge_i = stat.merge_hit;
  assign stat_del_i   = stat.carve_del;
  assign stat_split_i = stat.carve_split;
  assign probe_ok     = (cmd.i == i[IdxW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= '0;
      i <= '0; j <= '0; k <= '0;
      func <= '0;
    end else begin
      cmd <= '0;
      unique case (state)
        S_IDLE: if (start) begin
          func   <= req.func;
          cmd.op <= OP_LOAD;
          state  <= S_DISPATCH;
        end
        S_DISPATCH: begin
          i <= '0; j <= '0; k <= '0;
          priority case (func)
            FUNC_CLEAR:   begin cmd.op <= OP_CLEAR; state <= S_DUMP; end
            FUNC_APPEND:  begin cmd.op <= OP_APPEND; state <= S_DUMP; end
            FUNC_SORT:    state <= S_SORT;
            FUNC_CARVE:   state <= S_CARVE;
            FUNC_RESERVE: state <= S_RESERVE;
            default:      state <= S_DUMP;
          endcase
        end
        S_SORT: begin
          if (i >= stat.count) begin
            i <= '0;
            state <= S_MERGE;
          end else if (j >= stat.count) begin
            i <= i + CntW'(1);
            j <= i + CntW'(1);
          end else begin
            cmd.op <= OP_SORT_CMP;
            cmd.i  <= i[IdxW-1:0];
            cmd.j  <= j[IdxW-1:0];
            j <= j + CntW'(1);
          end
        end
        S_MERGE: begin
          if (cmd.op != OP_NONE) begin
          end else if (i + CntW'(1) >= stat.count) begin
            k <= '0;
            state <= S_DUMP;
          end else if (!probe_ok) begin
            cmd.i <= i[IdxW-1:0];
          end else begin
            cmd.i <= i[IdxW-1:0];
            if (stat_merge_i) begin
              cmd.op <= OP_MERGE;
              k <= i + CntW'(1);
              state <= S_MERGE_DEL;
            end else begin
              i <= i + CntW'(1);
            end
          end
        end
        S_MERGE_DEL, S_CARVE_DEL: begin
          if (k + CntW'(1) < stat.count) begin
            cmd.op <= OP_SHIFT_UP;
            cmd.k  <= k[IdxW-1:0];
            k <= k + CntW'(1);
          end else begin
            cmd.op <= OP_DEL_DONE;
            state  <= (state == S_MERGE_DEL) ? S_MERGE : S_CARVE;
          end
        end
        S_CARVE: begin
          if (cmd.op != OP_NONE) begin
          end else if (i >= stat.count) begin
            state <= S_CARVE_APP;
          end else if (!probe_ok) begin
            cmd.i <= i[IdxW-1:0];
          end else if (stat_del_i) begin
            k <= i;
            state <= S_CARVE_DEL;
          end else if (stat_split_i) begin
            if (stat.full) begin
              cmd.op <= OP_CARVE;
              cmd.i  <= i[IdxW-1:0];
              i <= i + CntW'(1);
            end else begin
              k <= stat.count;
              state <= S_SPLIT_SHIFT;
            end
          end else begin
            cmd.op <= OP_CARVE;
            cmd.i  <= i[IdxW-1:0];
            i <= i + CntW'(1);
          end
        end
        S_SPLIT_SHIFT: begin
          // Shifting down to i+1 leaves a full copy of entry i there, from
          // which the split write takes the old end.
          if (k > i) begin
            cmd.op <= OP_SHIFT_DN;
            cmd.k  <= k[IdxW-1:0];
            k <= k - CntW'(1);
          end else begin
            state <= S_SPLIT_WR;
          end
        end
        S_SPLIT_WR: begin
          cmd.op <= OP_SPLIT;
          cmd.i  <= i[IdxW-1:0];
          i <= i + CntW'(2);
          state <= S_CARVE;
        end
        S_CARVE_APP: begin
          cmd.op <= OP_APPEND;
          i <= '0; j <= '0;
          state <= S_SORT;
        end
        S_RESERVE: begin
          if (i >= stat.count) begin
            k <= '0;
            state <= S_DUMP;
          end else begin
            cmd.op <= OP_RESERVE;
            cmd.i  <= i[IdxW-1:0];
            i <= i + CntW'(1);
          end
        end
        S_DUMP: begin
          if (cmd.op == OP_DUMP || cmd.op == OP_NONE) begin
            if (cmd.op == OP_DUMP && cmd.last) begin
              state <= S_IDLE;
              k <= '0;
            end else begin
              cmd.op   <= OP_DUMP;
              cmd.k    <= k[IdxW-1:0];
              cmd.last <= (stat.count == '0) || (k + CntW'(1) >= n);
              k <= k + CntW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MRM_ASSERT_NEXT(a_idle_quiet, clk, rst, (state == S_IDLE) && !start, cmd.op == OP_NONE)
  `MRM_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `MRM_ASSERT_IMPL(a_split_room, clk, rst, cmd.op == OP_SHIFT_DN, !stat.full)
endmodule

// ----- rtl/memory_range_map_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory range map engine
// Typed address range table with sort, merge, carve and fixup commands.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low; the request only has
// to be valid at that edge. Every command ends in a dump of the table, one
// result per cycle on result with strobe high; the receiver cannot stall, so
// each result must be captured in its strobe cycle. An empty table dumps a
// single result with entry_valid low. Clear and append issue their command
// from the dispatch state and then dump one result per entry. Sort, carve and
// fixup walk the table one step per cycle: the exchange sort compares each entry
// with every later one, a merge or carve decision first presents the entry to
// the status logic unless cmd.i already holds it, and every delete or split adds
// one shift per moved entry. busy drops in the cycle that shows the last result,
// so the next transfer can be taken at the edge that ends the dump.
// ----------------------------------------------------------------------------
module memory_range_map_engine_core import mrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output logic strobe,
  output rsp_t result
);
  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_busy;
  logic  load;

  mrm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req(request),
    .stat(stat), .busy(ctrl_busy), .load(load), .cmd(cmd)
  );

  mrm_datapath u_dp (
    .clk(clk), .rst(rst), .load(load), .req(request), .cmd(cmd),
    .stat(stat), .strobe(strobe), .result(result)
  );

  // A dump command in flight also counts as busy.
  assign busy = ctrl_busy || (cmd.op == OP_DUMP);
endmodule

// ----- tb/range_map_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map checker
// Watches command and result transfers of the range map engine, keeps its
// own copy of the range table, and compares every result field by field.
// ----------------------------------------------------------------------------
module range_map_checker import mrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t request,
  input  logic strobe,
  input  rsp_t result,
  output int   fail_count,
  output int   pending
);
  logic [63:0] tbl_start [MaxRanges];
  logic [63:0] tbl_size [MaxRanges];
  logic [7:0]  tbl_kind [MaxRanges];
  int          tbl_n;
  rsp_t        dump_queue[$];

  function automatic void remove_at(int pos);
    for (int k = pos; k + 1 < tbl_n; k++) begin
      tbl_start[k] = tbl_start[k + 1];
      tbl_size[k] = tbl_size[k + 1];
      tbl_kind[k] = tbl_kind[k + 1];
    end
    tbl_n--;
  endfunction

  function automatic bit push_range(logic [7:0] kind, logic [63:0] s, logic [63:0] z);
    if (tbl_n >= MaxRanges) return 0;
    tbl_start[tbl_n] = s;
    tbl_size[tbl_n] = z;
    tbl_kind[tbl_n] = kind;
    tbl_n++;
    return 1;
  endfunction

  function automatic void order_and_join();
    logic [63:0] ts, tz, e, ne;
    logic [7:0]  tk;
    int          i;
    for (int a = 0; a < tbl_n; a++) begin
      for (int b = a; b < tbl_n; b++) begin
        if (tbl_start[b] < tbl_start[a]) begin
          ts = tbl_start[a]; tz = tbl_size[a]; tk = tbl_kind[a];
          tbl_start[a] = tbl_start[b]; tbl_size[a] = tbl_size[b];
          tbl_kind[a] = tbl_kind[b];
          tbl_start[b] = ts; tbl_size[b] = tz; tbl_kind[b] = tk;
        end
      end
    end
    i = 0;
    while (i + 1 < tbl_n) begin
      e = tbl_start[i] + tbl_size[i];
      ne = tbl_start[i + 1] + tbl_size[i + 1];
      if (tbl_kind[i] == tbl_kind[i + 1] && tbl_start[i] <= tbl_start[i + 1] &&
          e > tbl_start[i + 1]) begin
        if (e < ne) e = ne;
        tbl_size[i] = e - tbl_start[i];
        remove_at(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic bit cut_out(logic [63:0] s, logic [63:0] z);
    logic [63:0] e, ms, me;
    bit          ovf;
    int          i;
    e = s + z;
    ovf = 0;
    i = 0;
    while (i < tbl_n) begin
      ms = tbl_start[i];
      me = ms + tbl_size[i];
      if (s <= ms && e >= me) begin
        remove_at(i);
      end else if (s > ms && e < me) begin
        tbl_size[i] = s - ms;
        if (tbl_n < MaxRanges) begin
          for (int k = tbl_n; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k - 1];
            tbl_size[k] = tbl_size[k - 1];
            tbl_kind[k] = tbl_kind[k - 1];
          end
          tbl_n++;
          tbl_start[i + 1] = e;
          tbl_size[i + 1] = me - e;
          tbl_kind[i + 1] = tbl_kind[i];
          i += 2;
        end else begin
          ovf = 1;
          i++;
        end
      end else begin
        if (s <= ms && e > ms) begin
          tbl_start[i] = e;
          tbl_size[i] = me - e;
        end else if (s < me && s > ms) begin
          tbl_size[i] = s - ms;
        end
        i++;
      end
    end
    return ovf;
  endfunction

  function automatic void predict_dump(req_t req);
    logic [63:0] e, ms, me;
    bit          ovf;
    int          n;
    rsp_t        r;
    ovf = 0;
    case (req.func)
      FUNC_CLEAR: tbl_n = 0;
      FUNC_APPEND: ovf = !push_range(req.range_type, req.range_start, req.range_size);
      FUNC_SORT: order_and_join();
      FUNC_CARVE: begin
        ovf = cut_out(req.range_start, req.range_size);
        if (!push_range(req.range_type, req.range_start, req.range_size)) ovf = 1;
        order_and_join();
      end
      FUNC_RESERVE: begin
        e = req.range_start + req.range_size;
        for (int i = 0; i < tbl_n; i++) begin
          ms = tbl_start[i];
          me = ms + tbl_size[i];
          if (me == req.range_start) begin
            tbl_size[i] = e - ms;
          end else if (ms == req.range_start) begin
            tbl_start[i] = e;
            tbl_size[i] = me - e;
          end
        end
      end
      default: ;
    endcase
    if (tbl_n == 0) begin
      r = '0;
      r.overflow = ovf;
      r.last = 1;
      dump_queue.push_back(r);
    end else begin
      n = tbl_n < DumpLimit ? tbl_n : DumpLimit;
      for (int k = 0; k < n; k++) begin
        r.entry_index = k[3:0];
        r.entry_valid = 1;
        r.entry_start = tbl_start[k];
        r.entry_size = tbl_size[k];
        r.entry_type = tbl_kind[k];
        r.entry_total = tbl_n[4:0];
        r.overflow = ovf;
        r.last = (k + 1 == n);
        dump_queue.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      tbl_n = 0;
      fail_count = 0;
      dump_queue.delete();
    end else begin
      if (strobe) begin
        if (dump_queue.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, result);
          fail_count++;
        end else begin
          want = dump_queue.pop_front();
          if (result !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, result);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_dump(request);
    end
    pending = dump_queue.size();
  end
endmodule

// ----- tb/memory_range_map_engine_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range map engine testbench
// Drives directed and random command transfers into the engine and lets the
// checker predict and compare every dumped table entry.
// ----------------------------------------------------------------------------
module memory_range_map_engine_core_tb;
  import mrm_pkg::*;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic strobe;
  rsp_t result;
  int   fail_count;
  int   pending;
  int   sent;
  int   op_hist[8];

  memory_range_map_engine_core DUT (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .strobe(strobe), .result(result)
  );

  range_map_checker checker_inst (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a carve on a full table is the slowest command, so some 420 such
  // transfers with sender gaps stay well below this bound.
  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

  // Hands one command to the engine. Inputs change only on falling edges; the
  // transfer completes at the rising edge where start is high and busy is low.
  // Each call first moves to a fresh falling edge, so start is never assigned
  // twice in one time step.
  task automatic send_cmd(logic [2:0] f, logic [7:0] t, logic [63:0] s,
                          logic [63:0] z, bit gaps);
    @(negedge clk);
    while (gaps && $urandom_range(99) < 36) @(negedge clk);
    start <= 1;
    request <= '{func: f, range_type: t, range_start: s, range_size: z};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 0;
    request <= req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    op_hist[f]++;
    sent++;
  endtask

  // Addresses mostly sit in a narrow window so that ranges overlap, touch and
  // split each other; now and then a full 64-bit value makes wrapping ends.
  function automatic logic [63:0] pick_addr();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(64);
      default: return 64'(($urandom_range(63)) * 16 + ($urandom_range(3) == 0 ? 8 : 0));
    endcase
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'd0;
      default: return 64'($urandom_range(1, 12) * 16);
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 4) return FUNC_CLEAR;
    if (r < 34) return FUNC_APPEND;
    if (r < 49) return FUNC_SORT;
    if (r < 84) return FUNC_CARVE;
    if (r < 96) return FUNC_RESERVE;
    return 3'($urandom_range(5, 7));
  endfunction

  initial begin
    logic [63:0] base;
    bit          gaps;
    start = 0;
    request = '0;
    sent = 0;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: empty table dump, touching versus overlapping merge,
    // split, full-table overflow on append and on split, wrapping ends,
    // reserve fixup, and the unused command codes.
    send_cmd(FUNC_SORT, 8'h00, 64'h0, 64'h0, 0);
    send_cmd(FUNC_APPEND, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_cmd(FUNC_APPEND, 8'h01, 64'h100, 64'h100, 0);
    send_cmd(FUNC_APPEND, 8'h01, 64'h200, 64'h100, 0);
    send_cmd(FUNC_APPEND, 8'h01, 64'h280, 64'h100, 0);
    send_cmd(FUNC_SORT, 8'h00, 64'h0, 64'h0, 0);
    send_cmd(FUNC_CARVE, 8'h02, 64'h140, 64'h20, 0);
    send_cmd(FUNC_RESERVE, 8'h00, 64'h140, 64'h10, 0);
    send_cmd(FUNC_CARVE, 8'h03, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_cmd(FUNC_CLEAR, 8'h00, 64'h0, 64'h0, 0);
    for (int i = 0; i < 16; i++)
      send_cmd(FUNC_APPEND, 8'(i % 3), 64'(i * 64), 64'h30, 0);
    send_cmd(FUNC_APPEND, 8'h07, 64'h5000, 64'h10, 0);
    send_cmd(FUNC_CARVE, 8'h09, 64'h10, 64'h8, 0);
    send_cmd(3'd5, 8'h00, 64'h0, 64'h0, 0);
    send_cmd(3'd7, 8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0);
    send_cmd(FUNC_CLEAR, 8'h00, 64'h0, 64'h0, 0);

    // Random part. The first stretch runs with no sender gaps; halfway the
    // sender holds off until the whole table dump has been checked.
    for (int n = 0; n < 390; n++) begin
      gaps = n >= 60;
      if (n == 195) wait (pending == 0);
      base = pick_addr();
      send_cmd(pick_func(), 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(2)),
               base, pick_size(), gaps);
    end

    wait (pending == 0);
    repeat (400) @(posedge clk);
    $display("Sent %0d commands: clear %0d, append %0d, sort %0d, carve %0d, fixup %0d,",
             sent, op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4]);
    $display("unused codes %0d, with full tables, splits and wrapping ends.",
             op_hist[5] + op_hist[6] + op_hist[7]);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mrm_pkg.sv
rtl/mrm_datapath.sv
rtl/mrm_ctrl.sv
rtl/memory_range_map_engine_core.sv
tb/range_map_checker.sv
tb/memory_range_map_engine_core_tb.sv
